/* rtl/ncs_pkg.sv */
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared constants and types for the nearest codeword search unit.
// ----------------------------------------------------------------------------
package ncs_pkg;

    localparam int NUM_WORDS  = 64;   // dictionary words, one cell each (1..256)
    localparam int WORD_DIMS  = 64;   // elements per word (1..64)

    localparam int WORD_IDX_W = 6;
    localparam int DIM_IDX_W  = 6;
    localparam int ELEM_W     = 16;
    localparam int DIST_W     = 38;
    localparam int CFG_W      = 7;
    localparam int SQ_W       = 2 * ELEM_W;

    localparam int DIM_ADDR_W = (WORD_DIMS > 1) ? $clog2(WORD_DIMS) : 1;
    localparam int WORDS_CAP  = (NUM_WORDS < 64) ? NUM_WORDS : 64;

    // pipeline fill plus one chain hop per cell
    localparam int SEARCH_CYCLES = NUM_WORDS + 3;
    localparam int CNT_W         = $clog2(SEARCH_CYCLES + 1);

    // register indexes
    localparam logic REG_WORDS_IN_USE = 1'b0;
    localparam logic REG_DIMS_IN_USE  = 1'b1;

    // item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // running best handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic [WORD_IDX_W-1:0] idx;
        logic [DIST_W-1:0]     distance;
    } chain_t;

    // broadcast control to every cell
    typedef struct packed {
        logic accum;   // add the square now in stage 3
        logic clear;   // zero the accumulator
    } cell_ctrl_t;

endpackage

/* rtl/nearest_codeword_search_unit.sv */
// ----------------------------------------------------------------------------
// nearest_codeword_search_unit
// Vector quantizer: nearest dictionary word by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Load items (tuser = 0) write one dictionary element; query items (tuser = 1)
// add the squared difference of one feature element to every in-use word's
// distance. Both kinds are taken one per cycle. A query item with tlast set
// closes the vector: the block then stops taking items while the per-word
// multiply/accumulate pipeline empties, the running minimum passes down the
// chain of cells and the result is registered, and longer if an earlier
// result is still waiting on the output. The result carries the lowest-index
// word of least distance; distances saturate at 2^38 - 1 and are cleared
// once the result is issued.
// ----------------------------------------------------------------------------
module nearest_codeword_search_unit
    import ncs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // word_index, dim_index, element_value
    input  logic                 s_axis_tuser,  // opcode
    input  logic                 s_axis_tlast,  // last
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata   // best_word, best_distance
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CFG_W-1:0]       words_in_use_reg;
    logic [CFG_W-1:0]       dims_in_use_reg;
    logic [CFG_W-1:0]       nw;
    logic [CFG_W-1:0]       nd;

    logic [WORD_IDX_W-1:0]  word_index;
    logic [DIM_IDX_W-1:0]   dim_index;
    logic [ELEM_W-1:0]      element_value;
    logic                   accept;
    logic                   is_load;
    logic                   query_en;

    logic [ELEM_W-1:0]      query_s1_reg;
    logic                   en_s1_reg;
    logic                   en_s2_reg;
    logic                   en_s3_reg;

    logic                   out_valid_reg;
    logic [WORD_IDX_W-1:0]  best_word_reg;
    logic [DIST_W-1:0]      best_dist_reg;
    logic                   publish;

    cell_ctrl_t             ctrl;
    chain_t                 chain [NUM_WORDS+1];

    assign word_index    = s_axis_tdata[5:0];
    assign dim_index     = s_axis_tdata[11:6];
    assign element_value = s_axis_tdata[27:12];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_load       = accept && (s_axis_tuser == OP_LOAD)
                           && ({1'b0, dim_index} < CFG_W'(WORD_DIMS));

    // saturate the limits into their legal ranges
    always_comb
    begin
        nw = words_in_use_reg;
        if (words_in_use_reg == '0)
        begin
            nw = CFG_W'(1);
        end
        else if (words_in_use_reg > CFG_W'(WORDS_CAP))
        begin
            nw = CFG_W'(WORDS_CAP);
        end
        nd = dims_in_use_reg;
        if (dims_in_use_reg == '0)
        begin
            nd = CFG_W'(1);
        end
        else if (dims_in_use_reg > CFG_W'(WORD_DIMS))
        begin
            nd = CFG_W'(WORD_DIMS);
        end
    end

    assign query_en = accept && (s_axis_tuser == OP_QUERY) && ({1'b0, dim_index} < nd);

    assign publish = (state_reg == ST_SEARCH) && (cnt_reg == CNT_W'(SEARCH_CYCLES))
                     && (!out_valid_reg || m_axis_tready);

    assign ctrl.accum = en_s3_reg;
    assign ctrl.clear = publish;

    assign chain[0] = '0;

    for (genvar i = 0; i < NUM_WORDS; i++)
    begin : g_cell
        logic use_word;
        logic load_hit;

        if (i < 64)
        begin : g_addr
            assign use_word = (CFG_W'(i) < nw);
            assign load_hit = is_load && (word_index == WORD_IDX_W'(i));
        end
        else
        begin : g_none
            assign use_word = 1'b0;
            assign load_hit = 1'b0;
        end

        ncs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_use    (use_word),
            .cell_id   (WORD_IDX_W'(i)),
            .load_we   (load_hit),
            .load_addr (dim_index[DIM_ADDR_W-1:0]),
            .load_data (element_value),
            .rd_addr   (dim_index[DIM_ADDR_W-1:0]),
            .query_s1  (query_s1_reg),
            .ctrl      (ctrl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        query_s1_reg <= element_value;
        if (publish)
        begin
            best_word_reg <= chain[NUM_WORDS].idx;
            best_dist_reg <= chain[NUM_WORDS].distance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            words_in_use_reg <= CFG_W'(64);
            dims_in_use_reg  <= CFG_W'(64);
            en_s1_reg        <= 1'b0;
            en_s2_reg        <= 1'b0;
            en_s3_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WORDS_IN_USE: words_in_use_reg <= cfg_data;
                    REG_DIMS_IN_USE:  dims_in_use_reg  <= cfg_data;
                    default:          ;
                endcase
            end

            en_s1_reg <= query_en;
            en_s2_reg <= en_s1_reg;
            en_s3_reg <= en_s2_reg;

            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && (s_axis_tuser == OP_QUERY) && s_axis_tlast)
                    begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (cnt_reg != CNT_W'(SEARCH_CYCLES))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (publish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, best_dist_reg, best_word_reg};

endmodule

/* rtl/ncs_ram.sv */
// ----------------------------------------------------------------------------
// ncs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* rtl/ncs_cell.sv */
// ----------------------------------------------------------------------------
// ncs_cell
// One dictionary word: element store, squared-difference pipeline,
// saturating accumulator and one stage of the argmin chain.
// ----------------------------------------------------------------------------
module ncs_cell
    import ncs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_use,
    input  logic [WORD_IDX_W-1:0]   cell_id,
    input  logic                    load_we,
    input  logic [DIM_ADDR_W-1:0]   load_addr,
    input  logic [ELEM_W-1:0]       load_data,
    input  logic [DIM_ADDR_W-1:0]   rd_addr,
    input  logic [ELEM_W-1:0]       query_s1,
    input  cell_ctrl_t              ctrl,
    input  chain_t                  chain_in,
    output chain_t                  chain_out
);

    logic [ELEM_W-1:0]   dict_s1;
    logic [ELEM_W:0]     diff;
    logic [ELEM_W:0]     diff_abs;
    logic [ELEM_W-1:0]   abs_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [DIST_W:0]     sum;
    logic [DIST_W-1:0]   acc_reg;
    logic [DIST_W-1:0]   acc_next;
    chain_t              chain_reg;
    chain_t              chain_next;

    ncs_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (WORD_DIMS)
    ) u_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (load_data),
        .raddr (rd_addr),
        .rdata (dict_s1)
    );

    // |a - b| of two signed 16-bit values fits in 16 unsigned bits
    assign diff     = {query_s1[ELEM_W-1], query_s1} - {dict_s1[ELEM_W-1], dict_s1};
    assign diff_abs = diff[ELEM_W] ? (~diff + 1'b1) : diff;

    assign sum = {1'b0, acc_reg} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.accum && in_use)
        begin
            acc_next = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
        end
    end

    // strict less keeps the lower index on ties
    always_comb
    begin
        chain_next = chain_in;
        if (in_use && (!chain_in.valid || acc_reg < chain_in.distance))
        begin
            chain_next.valid    = 1'b1;
            chain_next.idx      = cell_id;
            chain_next.distance = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg <= diff_abs[ELEM_W-1:0];
        sq_reg  <= abs_reg * abs_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            chain_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;

endmodule

/* tb/nearest_codeword_search_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_codeword_search_unit_tb
// Self-checking bench for the nearest codeword search unit. Items carry
// dictionary loads and query elements. An in-bench model keeps its own
// dictionary and per-word distances and queues one expected match per
// closing query. Runs go through several register settings and idle/stall
// mixes. Queries only touch dictionary entries that were loaded earlier.
// ----------------------------------------------------------------------------
module nearest_codeword_search_unit_tb;
    import ncs_pkg::*;

    localparam int               QUIET_LIMIT = 4000;
    localparam int               SETTLE      = SEARCH_CYCLES + 8;
    localparam longint unsigned  DIST_CAP    = (64'd1 << DIST_W) - 1;

    typedef struct {
        logic                  op;
        logic [WORD_IDX_W-1:0] word;
        logic [DIM_IDX_W-1:0]  dim;
        logic [ELEM_W-1:0]     value;
        logic                  last;
    } vq_item_t;

    typedef struct {
        logic [WORD_IDX_W-1:0] word;
        logic [DIST_W-1:0]     distance;
    } nearest_match_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_index = REG_WORDS_IN_USE;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;  // word_index, dim_index, element_value
    logic              s_axis_tuser = OP_LOAD;  // opcode
    logic              s_axis_tlast = 1'b0;     // last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;   // best_word, best_distance

    nearest_codeword_search_unit dut (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    vq_item_t          stim_items[$];
    nearest_match_t    pending_matches[$];
    bit                item_on_bus = 1'b0;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                errors = 0;
    int                quiet_cycles = 0;

    // model state
    logic signed [ELEM_W-1:0] dict_model [NUM_WORDS][WORD_DIMS];
    longint unsigned          dist_acc [NUM_WORDS];
    logic [CFG_W-1:0]         model_words = 7'd64;
    logic [CFG_W-1:0]         model_dims = 7'd64;

    // generator view: which entries were loaded, and the active sizes
    bit                written [NUM_WORDS][WORD_DIMS];
    int                gen_nw = WORDS_CAP;
    int                gen_nd = WORD_DIMS;

    function automatic int clamp_cfg(input logic [CFG_W-1:0] raw, input int hi);
        if (raw == 0)
            return 1;
        if (raw > hi)
            return hi;
        return int'(raw);
    endfunction

    task automatic absorb_item(input logic op, input logic [WORD_IDX_W-1:0] w,
                               input logic [DIM_IDX_W-1:0] d,
                               input logic signed [ELEM_W-1:0] v, input logic lst);
        int              nw;
        int              nd;
        int              diff;
        longint unsigned sum;
        nearest_match_t  m;
        nw = clamp_cfg(model_words, WORDS_CAP);
        nd = clamp_cfg(model_dims, WORD_DIMS);
        if (op == OP_LOAD)
        begin
            if (w < NUM_WORDS && d < WORD_DIMS)
                dict_model[w][d] = v;
            return;
        end
        if (d < nd)
        begin
            for (int i = 0; i < nw; i++)
            begin
                diff = int'(v) - int'(dict_model[i][d]);
                sum = dist_acc[i] + longint'(diff) * longint'(diff);
                dist_acc[i] = (sum > DIST_CAP) ? DIST_CAP : sum;
            end
        end
        if (!lst)
            return;
        m.word = '0;
        m.distance = dist_acc[0][DIST_W-1:0];
        for (int i = 1; i < nw; i++)
        begin
            if (dist_acc[i] < m.distance)
            begin
                m.word = i[WORD_IDX_W-1:0];
                m.distance = dist_acc[i][DIST_W-1:0];
            end
        end
        pending_matches.push_back(m);
        foreach (dist_acc[i])
            dist_acc[i] = 0;
    endtask

    // sample side: model update, result check, quiet counter
    always @(posedge clk)
    begin
        nearest_match_t exp_m;
        bit             active;
        active = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WORDS_IN_USE)
                    model_words = cfg_data;
                else
                    model_dims = cfg_data;
                active = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_item(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6],
                            s_axis_tdata[27:12], s_axis_tlast);
                item_on_bus = 1'b0;
                active = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                active = 1'b1;
                if (pending_matches.size() == 0)
                begin
                    $error("unexpected result: best_word %0d best_distance %0d",
                           m_axis_tdata[5:0], m_axis_tdata[43:6]);
                    errors++;
                end
                else
                begin
                    exp_m = pending_matches.pop_front();
                    if (m_axis_tdata[5:0] !== exp_m.word)
                    begin
                        $error("best_word: expected %0d, got %0d",
                               exp_m.word, m_axis_tdata[5:0]);
                        errors++;
                    end
                    if (m_axis_tdata[43:6] !== exp_m.distance)
                    begin
                        $error("best_distance: expected %0d, got %0d",
                               exp_m.distance, m_axis_tdata[43:6]);
                        errors++;
                    end
                end
            end
            quiet_cycles <= active ? 0 : quiet_cycles + 1;
        end
    end

    // drive side
    always @(negedge clk)
    begin
        vq_item_t it;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            if (!item_on_bus)
            begin
                if (stim_items.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    it = stim_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= it.op;
                    s_axis_tlast  <= it.last;
                    s_axis_tdata  <= {4'b0, it.value, it.dim, it.word};
                    item_on_bus = 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("nearest_codeword_search_unit_tb: done, errors");
        $finish;
    end

    task automatic push_load(input int w, input int d, input int v);
        vq_item_t it;
        it.op = OP_LOAD;
        it.word = w[WORD_IDX_W-1:0];
        it.dim = d[DIM_IDX_W-1:0];
        it.value = v[ELEM_W-1:0];
        it.last = 1'($urandom_range(0, 1));  // ignored on loads
        stim_items.push_back(it);
        written[w][d] = 1'b1;
    endtask

    task automatic push_query(input int d, input int v, input bit lst);
        vq_item_t it;
        it.op = OP_QUERY;
        it.word = WORD_IDX_W'($urandom_range(0, 63));
        it.dim = d[DIM_IDX_W-1:0];
        it.value = v[ELEM_W-1:0];
        it.last = lst;
        stim_items.push_back(it);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_d);
        write_reg(REG_WORDS_IN_USE, raw_w);
        write_reg(REG_DIMS_IN_USE, raw_d);
        gen_nw = clamp_cfg(raw_w, WORDS_CAP);
        gen_nd = clamp_cfg(raw_d, WORD_DIMS);
    endtask

    // sender holds off until every expected match is back, then the block settles
    task automatic drain();
        while (stim_items.size() != 0 || item_on_bus || pending_matches.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic build_phase(input int target);
        int n;
        int len;
        int d;
        int hi;
        n = 0;
        // every entry a query may read gets loaded first
        for (int w = 0; w < gen_nw; w++)
            for (int k = 0; k < gen_nd; k++)
                if (!written[w][k])
                begin
                    push_load(w, k, pick_value());
                    n++;
                end
        while (n < target)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        push_load($urandom_range(0, 63), $urandom_range(0, 63), pick_value());
                        n++;
                    end
                end
                1:
                begin
                    // opposite extremes repeated on one dimension drive distances to the cap
                    if (gen_nw <= 8)
                    begin
                        d = $urandom_range(0, gen_nd - 1);
                        for (int w = 0; w < gen_nw; w++)
                            push_load(w, d, -32768);
                        len = $urandom_range(66, 70);
                        for (int i = 0; i < len; i++)
                            push_query(d, 32767, i == len - 1);
                        n += gen_nw + len;
                    end
                end
                default:
                begin
                    hi = (gen_nd + 2 < 10) ? gen_nd + 2 : 10;
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, gen_nd + 4)
                                                      : $urandom_range(1, hi);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 15) == 0)
                        begin
                            push_load($urandom_range(0, gen_nw - 1),
                                      $urandom_range(0, gen_nd - 1), pick_value());
                            n++;
                        end
                        if (gen_nd < WORD_DIMS && $urandom_range(0, 7) == 0)
                            d = $urandom_range(gen_nd, 63);
                        else
                            d = $urandom_range(0, gen_nd - 1);
                        push_query(d, pick_value(), i == len - 1);
                        n++;
                    end
                end
            endcase
        end
    endtask

    task automatic set_mode(input int mode);
        case (mode % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 68; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 25; stall_pct = 25; end
        endcase
    endtask

    initial
    begin
        logic [CFG_W-1:0] raw_words [9];
        logic [CFG_W-1:0] raw_dims [9];
        foreach (dist_acc[i])
            dist_acc[i] = 0;
        foreach (dict_model[i, j])
            dict_model[i][j] = '0;
        raw_words = '{7'd3, 7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd4, 7'd8, 7'd6};
        raw_dims  = '{7'd5, 7'd64, 7'd1, 7'd0, 7'd2, 7'd127, 7'd6, 7'd8, 7'd3};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: two words, four dims
        set_sizes(7'd2, 7'd4);
        push_load(0, 0, -32768);
        push_load(0, 1, 32767);
        push_load(0, 2, 0);
        push_load(0, 3, 5);
        push_load(1, 0, -32768);
        push_load(1, 1, 32767);
        push_load(1, 2, 0);
        push_load(1, 3, -5);
        push_load(63, 63, 32767);
        // equal distances: lowest index wins
        push_query(0, -32768, 1'b0);
        push_query(1, 32767, 1'b0);
        push_query(2, 0, 1'b0);
        push_query(3, 0, 1'b1);
        // full-scale difference, word 1 nearer
        push_query(0, 32767, 1'b0);
        push_query(3, -5, 1'b1);
        // dimension past the active count still closes the vector
        push_query(63, 12345, 1'b1);
        push_query(2, -32768, 1'b0);
        push_query(40, 32767, 1'b1);
        set_mode(0);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            set_sizes(raw_words[p], raw_dims[p]);
            set_mode(p);
            build_phase(115);
            drain();
        end

        if (pending_matches.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_matches.size());
            errors++;
        end
        if (errors == 0)
            $display("nearest_codeword_search_unit_tb: done, clean");
        else
            $display("nearest_codeword_search_unit_tb: done, errors");
        $finish;
    end

endmodule
